// File: design/rce_pkg.sv
// Shared types and constants of the checked postfix integer evaluator.
`default_nettype none
package rce_pkg;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_APPLY = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_LCM = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_OVF    = 3'd1,
    ST_DIVZ   = 3'd2,
    ST_UNDER  = 3'd3,
    ST_EMPTY  = 3'd4,
    ST_FULL   = 3'd5,
    ST_UNKOP  = 3'd6,
    ST_LCMARG = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    K_PUSH,
    K_APPLY,
    K_END
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] number;
    logic [2:0]  op;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic [63:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_MUL_CHK,
    S_DIV_WAIT,
    S_GCD_CHK,
    S_GCD_WAIT,
    S_LCMQ_WAIT
  } state_t;

endpackage
`default_nettype wire

// File: design/rce_front.sv
// Front end: takes input transfers, classifies them and queues them for execution.
`default_nettype none
module rce_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          action,
  input  wire logic signed [63:0]  number,
  input  wire logic [2:0]          operator_code,
  output logic                     q_valid,
  output rce_pkg::item_t           q_item,
  input  wire logic                q_pop
);

  rce_pkg::item_t queue [rce_pkg::QUEUE_DEPTH];
  logic [rce_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [rce_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [rce_pkg::QUEUE_AW:0]   fill;
  logic                         push;
  logic                         known;
  rce_pkg::item_t               new_item;

  always_comb begin
    known         = 1'b1;
    new_item.kind = rce_pkg::K_PUSH;
    unique case (action)
      rce_pkg::ACT_PUSH:  new_item.kind = rce_pkg::K_PUSH;
      rce_pkg::ACT_APPLY: new_item.kind = rce_pkg::K_APPLY;
      rce_pkg::ACT_END:   new_item.kind = rce_pkg::K_END;
      default:            known = 1'b0;
    endcase
    new_item.number = number;
    new_item.op     = operator_code;
  end

  assign in_ready = (fill != (rce_pkg::QUEUE_AW + 1)'(rce_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (fill != '0);
  assign q_item   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/rce_divu.sv
// Restoring unsigned 64-bit divider, one quotient bit per cycle.
`default_nettype none
module rce_divu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rce_pkg::div_req_t req,
  output rce_pkg::div_rsp_t      rsp
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [6:0]  steps;
  logic        running;
  logic        done;
  logic [64:0] shifted;
  logic [64:0] trial;

  assign shifted = {rem, quo[63]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (running) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted[63:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      steps   <= '0;
      done    <= 1'b0;
    end else begin
      done <= running && (steps == 7'd1);
      if (req.start) begin
        running <= 1'b1;
        steps   <= 7'd64;
      end else if (running) begin
        steps <= steps - 7'd1;
        if (steps == 7'd1) begin
          running <= 1'b0;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

// File: design/rce_back.sv
// Back end: operand stack, sequencer, shift-add multiplier and result register.
`default_nettype none
module rce_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire rce_pkg::item_t     q_item,
  output logic                    q_pop,
  output rce_pkg::div_req_t       div_req,
  input  wire rce_pkg::div_rsp_t  div_rsp,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      value,
  output logic [2:0]              status
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [63:0] mem [STACK_DEPTH];
  logic [63:0] rd_data;

  rce_pkg::state_t  state;
  rce_pkg::state_t  state_next;
  rce_pkg::status_t err;
  logic [CW-1:0]    count;
  logic [63:0]      tos;
  logic [63:0]      a_reg;
  logic [63:0]      b_reg;
  logic [2:0]       op_reg;
  logic             neg;
  logic [127:0]     acc;
  logic [63:0]      mul_a;
  logic [63:0]      mul_b;
  logic [5:0]       mul_cnt;
  logic [63:0]      gx;
  logic [63:0]      gy;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic          is_full;
  logic          out_held;
  logic          mem_we;
  logic [63:0]   sum;
  logic [63:0]   dif;
  logic          add_ovf;
  logic          sub_ovf;
  logic [63:0]   mag_a;
  logic [63:0]   mag_b;
  logic          div_bad;
  logic          mod_bad;
  logic          lcm_bad;
  logic          op_unknown;
  logic [63:0]   limit;
  logic          mul_ovf;
  logic [63:0]   rem_s;

  assign cnt_m1     = count - CW'(1);
  assign cnt_m2     = count - CW'(2);
  assign is_full    = (count == CW'(STACK_DEPTH));
  assign out_held   = out_valid && !out_ready;
  assign op_unknown = (q_item.op > 3'(rce_pkg::OP_LCM));

  assign sum     = rd_data + b_reg;
  assign dif     = rd_data - b_reg;
  assign add_ovf = !(rd_data[63] ^ b_reg[63]) && (sum[63] ^ rd_data[63]);
  assign sub_ovf = (rd_data[63] ^ b_reg[63]) && (dif[63] ^ rd_data[63]);
  assign mag_a   = rd_data[63] ? (~rd_data + 64'd1) : rd_data;
  assign mag_b   = b_reg[63] ? (~b_reg + 64'd1) : b_reg;
  assign div_bad = (b_reg == '0) || ((rd_data == rce_pkg::SIGN_BIT) && (b_reg == '1));
  assign mod_bad = (b_reg == '0) || (b_reg == '1);
  assign lcm_bad = rd_data[63] || (rd_data == '0) || b_reg[63] || (b_reg == '0);

  assign limit   = neg ? rce_pkg::SIGN_BIT : rce_pkg::MAX_POS;
  assign mul_ovf = (acc[127:64] != '0) || (acc[63:0] > limit);
  assign rem_s   = a_reg[63] ? (~div_rsp.remainder + 64'd1) : div_rsp.remainder;

  // Stack memory: entries below the top; the top itself lives in tos.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_m1[AW-1:0]] <= tos;
    end
    rd_data <= mem[cnt_m2[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rce_pkg::S_IDLE: begin
        if (q_valid && (q_item.kind == rce_pkg::K_APPLY) && (err == rce_pkg::ST_OK) &&
            !op_unknown && (count >= CW'(2))) begin
          state_next = rce_pkg::S_EXEC;
        end
      end
      rce_pkg::S_EXEC: begin
        state_next = rce_pkg::S_IDLE;
        unique case (op_reg)
          rce_pkg::OP_MUL: state_next = rce_pkg::S_MUL;
          rce_pkg::OP_DIV: if (!div_bad) state_next = rce_pkg::S_DIV_WAIT;
          rce_pkg::OP_MOD: if (!mod_bad) state_next = rce_pkg::S_DIV_WAIT;
          rce_pkg::OP_LCM: if (!lcm_bad) state_next = rce_pkg::S_GCD_CHK;
          default:         state_next = rce_pkg::S_IDLE;
        endcase
      end
      rce_pkg::S_MUL:       if (mul_cnt == '1) state_next = rce_pkg::S_MUL_CHK;
      rce_pkg::S_MUL_CHK:   state_next = rce_pkg::S_IDLE;
      rce_pkg::S_DIV_WAIT:  if (div_rsp.done) state_next = rce_pkg::S_IDLE;
      rce_pkg::S_GCD_CHK:   state_next = (gy == '0) ? rce_pkg::S_LCMQ_WAIT
                                                    : rce_pkg::S_GCD_WAIT;
      rce_pkg::S_GCD_WAIT:  if (div_rsp.done) state_next = rce_pkg::S_GCD_CHK;
      rce_pkg::S_LCMQ_WAIT: if (div_rsp.done) state_next = rce_pkg::S_MUL;
      default:              state_next = rce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop            = 1'b0;
    mem_we           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mag_a;
    div_req.divisor  = mag_b;
    unique case (state)
      rce_pkg::S_IDLE: begin
        q_pop  = q_valid && !((q_item.kind == rce_pkg::K_END) && out_held);
        mem_we = q_valid && (q_item.kind == rce_pkg::K_PUSH) && (err == rce_pkg::ST_OK) &&
                 !is_full && (count != '0);
      end
      rce_pkg::S_EXEC: begin
        div_req.start = ((op_reg == rce_pkg::OP_DIV) && !div_bad) ||
                        ((op_reg == rce_pkg::OP_MOD) && !mod_bad);
      end
      rce_pkg::S_GCD_CHK: begin
        div_req.start = 1'b1;
        if (gy == '0) begin
          div_req.dividend = a_reg;
          div_req.divisor  = gx;
        end else begin
          div_req.dividend = gx;
          div_req.divisor  = gy;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rce_pkg::S_IDLE;
      count     <= '0;
      err       <= rce_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        rce_pkg::S_IDLE: begin
          if (q_pop) begin
            unique case (q_item.kind)
              rce_pkg::K_PUSH: begin
                if (err == rce_pkg::ST_OK) begin
                  if (is_full) begin
                    err <= rce_pkg::ST_FULL;
                  end else begin
                    tos   <= q_item.number;
                    count <= count + CW'(1);
                  end
                end
              end
              rce_pkg::K_APPLY: begin
                if (err == rce_pkg::ST_OK) begin
                  if (op_unknown) begin
                    err <= rce_pkg::ST_UNKOP;
                  end else if (count < CW'(2)) begin
                    err <= rce_pkg::ST_UNDER;
                  end else begin
                    b_reg  <= tos;
                    op_reg <= q_item.op;
                  end
                end
              end
              rce_pkg::K_END: begin
                out_valid <= 1'b1;
                if (err != rce_pkg::ST_OK) begin
                  value  <= '0;
                  status <= err;
                end else if (count == '0) begin
                  value  <= '0;
                  status <= rce_pkg::ST_EMPTY;
                end else begin
                  value  <= tos;
                  status <= rce_pkg::ST_OK;
                end
                count <= '0;
                err   <= rce_pkg::ST_OK;
              end
              default: begin
                count <= count;
              end
            endcase
          end
        end
        rce_pkg::S_EXEC: begin
          a_reg <= rd_data;
          unique case (op_reg)
            rce_pkg::OP_ADD: begin
              if (add_ovf) begin
                err <= rce_pkg::ST_OVF;
              end else begin
                tos   <= sum;
                count <= cnt_m1;
              end
            end
            rce_pkg::OP_SUB: begin
              if (sub_ovf) begin
                err <= rce_pkg::ST_OVF;
              end else begin
                tos   <= dif;
                count <= cnt_m1;
              end
            end
            rce_pkg::OP_MUL: begin
              mul_a   <= mag_a;
              mul_b   <= mag_b;
              neg     <= rd_data[63] ^ b_reg[63];
              acc     <= '0;
              mul_cnt <= '0;
            end
            rce_pkg::OP_DIV: begin
              neg <= rd_data[63] ^ b_reg[63];
              if (b_reg == '0) begin
                err <= rce_pkg::ST_DIVZ;
              end else if (div_bad) begin
                err <= rce_pkg::ST_OVF;
              end
            end
            rce_pkg::OP_MOD: begin
              if (b_reg == '0) begin
                err <= rce_pkg::ST_DIVZ;
              end else if (mod_bad) begin
                tos   <= '0;
                count <= cnt_m1;
              end
            end
            rce_pkg::OP_LCM: begin
              if (lcm_bad) begin
                err <= rce_pkg::ST_LCMARG;
              end else begin
                gx <= rd_data;
                gy <= b_reg;
              end
            end
            default: begin
              err <= err;
            end
          endcase
        end
        rce_pkg::S_MUL: begin
          acc     <= {acc[126:0], 1'b0} + (mul_a[63] ? {64'd0, mul_b} : 128'd0);
          mul_a   <= {mul_a[62:0], 1'b0};
          mul_cnt <= mul_cnt + 6'd1;
        end
        rce_pkg::S_MUL_CHK: begin
          if (mul_ovf) begin
            err <= rce_pkg::ST_OVF;
          end else begin
            tos   <= neg ? (~acc[63:0] + 64'd1) : acc[63:0];
            count <= cnt_m1;
          end
        end
        rce_pkg::S_DIV_WAIT: begin
          if (div_rsp.done) begin
            count <= cnt_m1;
            if (op_reg == rce_pkg::OP_DIV) begin
              tos <= neg ? (~div_rsp.quotient + 64'd1) : div_rsp.quotient;
            end else if ((div_rsp.remainder != '0) && (a_reg[63] != b_reg[63])) begin
              // Floored modulo: move a nonzero remainder over to the divisor's sign.
              tos <= rem_s + b_reg;
            end else begin
              tos <= rem_s;
            end
          end
        end
        rce_pkg::S_GCD_WAIT: begin
          if (div_rsp.done) begin
            gx <= gy;
            gy <= div_rsp.remainder;
          end
        end
        rce_pkg::S_LCMQ_WAIT: begin
          if (div_rsp.done) begin
            mul_a   <= div_rsp.quotient;
            mul_b   <= b_reg;
            neg     <= 1'b0;
            acc     <= '0;
            mul_cnt <= '0;
          end
        end
        default: begin
          err <= err;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/rpn_checked_integer_evaluator_top.sv
// Top level of the checked postfix integer evaluator.
// The block evaluates a postfix token stream over signed 64-bit integers.
// Input transfers carry action, number and operator_code on in_valid/in_ready.
// A push places number on the operand stack, an apply pops b then a and
// pushes a op b, and an end transfer produces one output transfer of value
// and status on out_valid/out_ready, then clears the stack and the error.
// The first fault is sticky: later pushes and operators are ignored until end.
// A front end queues up to two items, so input keeps flowing while the back
// end computes or while an output result waits for the receiver.
// In the back end, a push or end is handled in the idle state; add and
// subtract also wait for the registered stack memory read, multiply runs in
// the one-bit shift-add multiplier, and divide and modulo run in the one-bit
// restoring divider. Lcm runs Euclid on that divider, one divide per
// remainder step, then one divide and one multiply.
// A stalled receiver holds the output register; an end item then waits in
// the queue, and the queue fills and drops in_ready after two items.
// Reset empties the queue and the stack and clears the sticky error.
`default_nettype none
module rpn_checked_integer_evaluator_top #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         action,
  input  wire logic signed [63:0] number,
  input  wire logic [2:0]         operator_code,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      value,
  output logic [2:0]              status
);

  logic              q_valid;
  logic              q_pop;
  rce_pkg::item_t    q_item;
  rce_pkg::div_req_t div_req;
  rce_pkg::div_rsp_t div_rsp;

  // The front end classifies each transfer and queues it; unused actions drop here.
  rce_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .number        (number),
    .operator_code (operator_code),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // The divider is shared by divide, modulo, every step of the gcd and the lcm quotient.
  rce_divu u_divu (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rce_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
  );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the checked postfix integer evaluator: random postfix streams with a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int unsigned DEPTH     = 32;
  localparam int unsigned N_ITEMS   = 1850;
  localparam int unsigned IDLE_PCT  = 28;
  // The longest lcm run on worst-case operands, with a stalled receiver on top
  // of it, still stays far below this.
  localparam int unsigned STALL_MAX = 40000;
  localparam logic [1:0]  ACT_NONE  = 2'd3;
  localparam logic [2:0]  OP_BAD6   = 3'd6;
  localparam logic [2:0]  OP_BAD7   = 3'd7;
  localparam logic [63:0] MIN_NEG   = rce_pkg::SIGN_BIT;
  localparam logic [63:0] MINUS_ONE = '1;

  // Keeps a private copy of the operand stack and the sticky error, and
  // the queue of end results that the block still owes.
  class eval_scoreboard;
    logic [63:0]      stack_mem [DEPTH];
    int unsigned      depth;
    rce_pkg::status_t sticky;
    logic [63:0]      want_value [$];
    rce_pkg::status_t want_status [$];
    int unsigned      n_fail;
    int unsigned      n_ok;
    int unsigned      n_err;

    function new();
      depth  = 0;
      sticky = rce_pkg::ST_OK;
      n_fail = 0;
      n_ok   = 0;
      n_err  = 0;
    endfunction

    // Works out a op b; returns the fault, or ST_OK with the result in r.
    function rce_pkg::status_t evaluate(logic [2:0] opc, logic [63:0] a, logic [63:0] b,
                                        output logic [63:0] r);
      logic [63:0] ua, ub, x, y, t;
      logic [127:0] prod;
      logic signed [63:0] sm;
      logic neg;
      r = '0;
      case (opc)
        rce_pkg::OP_ADD: begin
          r = a + b;
          if (a[63] == b[63] && r[63] != a[63]) return rce_pkg::ST_OVF;
        end
        rce_pkg::OP_SUB: begin
          r = a - b;
          if (a[63] != b[63] && r[63] != a[63]) return rce_pkg::ST_OVF;
        end
        rce_pkg::OP_MUL: begin
          ua = a[63] ? -a : a;
          ub = b[63] ? -b : b;
          neg = a[63] ^ b[63];
          prod = ua * ub;
          if (prod > (neg ? {64'd0, rce_pkg::SIGN_BIT} : {64'd0, rce_pkg::MAX_POS}))
            return rce_pkg::ST_OVF;
          r = neg ? -prod[63:0] : prod[63:0];
        end
        rce_pkg::OP_DIV: begin
          if (b == 0) return rce_pkg::ST_DIVZ;
          if (a == MIN_NEG && b == MINUS_ONE) return rce_pkg::ST_OVF;
          r = $signed(a) / $signed(b);
        end
        rce_pkg::OP_MOD: begin
          if (b == 0) return rce_pkg::ST_DIVZ;
          if (b == MINUS_ONE) return rce_pkg::ST_OK;
          sm = $signed(a) % $signed(b);
          // Floored modulo follows the sign of the divisor.
          if (sm != 0 && (sm[63] != b[63])) sm = sm + $signed(b);
          r = sm;
        end
        rce_pkg::OP_LCM: begin
          if (a[63] || a == 0 || b[63] || b == 0) return rce_pkg::ST_LCMARG;
          x = a;
          y = b;
          while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
          end
          prod = (a / x) * b;
          if (prod > {64'd0, rce_pkg::MAX_POS}) return rce_pkg::ST_OVF;
          r = prod[63:0];
        end
        default: return rce_pkg::ST_UNKOP;
      endcase
      return rce_pkg::ST_OK;
    endfunction

    function void note_input(logic [1:0] act, logic [63:0] num, logic [2:0] opc);
      logic [63:0] r;
      rce_pkg::status_t st;
      if (act == rce_pkg::ACT_PUSH && sticky == rce_pkg::ST_OK) begin
        if (depth >= DEPTH) sticky = rce_pkg::ST_FULL;
        else begin
          stack_mem[depth] = num;
          depth++;
        end
      end else if (act == rce_pkg::ACT_APPLY && sticky == rce_pkg::ST_OK) begin
        // An unknown code is reported before the operand count.
        if (opc > rce_pkg::OP_LCM) sticky = rce_pkg::ST_UNKOP;
        else if (depth < 2) sticky = rce_pkg::ST_UNDER;
        else begin
          st = evaluate(opc, stack_mem[depth-2], stack_mem[depth-1], r);
          if (st != rce_pkg::ST_OK) sticky = st;
          else begin
            depth--;
            stack_mem[depth-1] = r;
          end
        end
      end else if (act == rce_pkg::ACT_END) begin
        if (sticky != rce_pkg::ST_OK) begin
          want_value.push_back('0);
          want_status.push_back(sticky);
        end else if (depth == 0) begin
          want_value.push_back('0);
          want_status.push_back(rce_pkg::ST_EMPTY);
        end else begin
          want_value.push_back(stack_mem[depth-1]);
          want_status.push_back(rce_pkg::ST_OK);
        end
        depth  = 0;
        sticky = rce_pkg::ST_OK;
      end
    endfunction

    function void check_result(logic [63:0] v, logic [2:0] s);
      logic [63:0] ev;
      rce_pkg::status_t es;
      if (want_status.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d", $time, $signed(v), s);
        n_fail++;
        return;
      end
      ev = want_value.pop_front();
      es = want_status.pop_front();
      if (es == rce_pkg::ST_OK) n_ok++;
      else n_err++;
      if (v !== ev) begin
        $display("%0t: value mismatch expected=%0d actual=%0d", $time, $signed(ev),
                 $signed(v));
        n_fail++;
      end
      if (s !== es) begin
        $display("%0t: status mismatch expected=%0d actual=%0d", $time, es, s);
        n_fail++;
      end
    endfunction

    function int unsigned pending();
      return want_status.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         action = rce_pkg::ACT_PUSH;
  logic signed [63:0] number = '0;
  logic [2:0]         operator_code = rce_pkg::OP_ADD;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] value;
  logic [2:0]         status;

  eval_scoreboard sb = new();
  bit          idle_on = 1'b1;
  int unsigned sent = 0;
  int unsigned quiet_cycles = 0;

  rpn_checked_integer_evaluator_top #(.STACK_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .number(number), .operator_code(operator_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: every transfer is checked against the oldest expectation.
  // The receiver stalls at random, except in the stretch with no idling.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(value, status);
    out_ready <= !rst && !(idle_on && $urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("watchdog: no transfer for %0d cycles, %0d results owed", STALL_MAX,
               sb.pending());
      $display("** rpn_checked_integer_evaluator_top: FAILED **");
      $finish;
    end
  end

  // Offers one item and holds it until the transfer happens. Random idle
  // cycles go in front of it, so gaps land at every point of the work.
  task automatic send(logic [1:0] act, logic [63:0] num, logic [2:0] opc);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    number        <= num;
    operator_code <= opc;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, num, opc);
    sent++;
  endtask

  task automatic push(logic [63:0] num);
    send(rce_pkg::ACT_PUSH, num, 3'($urandom));
  endtask

  task automatic apply(logic [2:0] opc);
    send(rce_pkg::ACT_APPLY, {$urandom, $urandom}, opc);
  endtask

  task automatic finish_expr();
    send(rce_pkg::ACT_END, {$urandom, $urandom}, 3'($urandom));
  endtask

  task automatic binary(logic [63:0] a, logic [63:0] b, logic [2:0] opc);
    push(a);
    push(b);
    apply(opc);
    finish_expr();
  endtask

  // Operand mix: small values in four of ten picks so that chains stay error free, plus
  // full-width values, the extremes and values near the overflow edges.
  function automatic logic [63:0] pick_number();
    case ($urandom_range(9))
      0, 1, 2, 3: return 64'($signed($urandom_range(40)) - 20);
      4:       return {$urandom, $urandom};
      5:       return 64'($urandom_range(100000));
      6: begin
        case ($urandom_range(4))
          0: return MIN_NEG;
          1: return rce_pkg::MAX_POS;
          2: return MINUS_ONE;
          3: return 64'd1;
          default: return 64'd0;
        endcase
      end
      7:       return 64'd1 << $urandom_range(63);
      8:       return {32'd0, $urandom};
      default: return 64'($urandom_range(1000000000)) * 64'($urandom_range(1000000000));
    endcase
  endfunction

  // A well-formed expression: pushes and operators kept in balance, ending
  // with an end item. Now and then a noise item or a wrong step is mixed in.
  task automatic random_expression();
    int unsigned held;
    int unsigned steps;
    held  = 0;
    steps = $urandom_range(1, 12);
    repeat (steps) begin
      if ($urandom_range(99) < 4) begin
        send(2'($urandom), {$urandom, $urandom}, 3'($urandom));
      end else if (held >= 2 && $urandom_range(1)) begin
        apply(3'($urandom_range(5)));
        held--;
      end else begin
        push(pick_number());
        held++;
      end
    end
    while (held > 1 && $urandom_range(3) != 0) begin
      apply(3'($urandom_range(5)));
      held--;
    end
    finish_expr();
  endtask

  initial begin
    int unsigned n_expr;
    n_expr = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: every operator at its edges and every fault.
    finish_expr();                                        // end on an empty stack
    binary(rce_pkg::MAX_POS, 64'd1, rce_pkg::OP_ADD);     // add overflow upward
    binary(MIN_NEG, MINUS_ONE, rce_pkg::OP_ADD);          // add overflow downward
    binary(MIN_NEG, 64'd1, rce_pkg::OP_SUB);              // subtract overflow
    binary(rce_pkg::MAX_POS, MIN_NEG, rce_pkg::OP_MUL);
    binary(MIN_NEG, 64'd1, rce_pkg::OP_MUL);              // product exactly the minimum
    binary(MIN_NEG, MINUS_ONE, rce_pkg::OP_DIV);          // minimum over minus one
    binary(64'd7, 64'd0, rce_pkg::OP_DIV);                // divide by zero
    binary(-64'sd7, 64'd2, rce_pkg::OP_MOD);              // floored modulo sign
    binary(MIN_NEG, MINUS_ONE, rce_pkg::OP_MOD);          // modulo by minus one
    binary(64'd4, 64'd6, rce_pkg::OP_LCM);
    binary(64'd0, 64'd6, rce_pkg::OP_LCM);                // lcm of a non-positive operand
    binary(rce_pkg::MAX_POS, rce_pkg::MAX_POS - 1, rce_pkg::OP_LCM); // lcm beyond the maximum
    push(64'd3);
    apply(OP_BAD6);                                       // unknown operator
    apply(rce_pkg::OP_ADD);                               // ignored behind the sticky error
    finish_expr();
    apply(OP_BAD7);
    finish_expr();
    apply(rce_pkg::OP_SUB);                               // too few operands
    send(ACT_NONE, rce_pkg::MAX_POS, OP_BAD7);            // unused action code
    finish_expr();
    repeat (DEPTH + 1) push(64'd5);                       // one push beyond full
    finish_expr();

    // Random part, with a stretch where neither side idles.
    while (sent < N_ITEMS) begin
      idle_on = !(sent > N_ITEMS / 3 && sent < N_ITEMS / 2);
      random_expression();
      n_expr++;
    end
    idle_on = 1'b1;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Ran %0d items in %0d random expressions after the directed cases.", sent, n_expr);
    $display("Results checked: %0d good values and %0d error reports.", sb.n_ok, sb.n_err);
    if (sb.n_fail == 0) begin
      $display("** rpn_checked_integer_evaluator_top: PASSED **");
    end else begin
      $display("** rpn_checked_integer_evaluator_top: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
design/rce_pkg.sv
design/rce_front.sv
design/rce_divu.sv
design/rce_back.sv
design/rpn_checked_integer_evaluator_top.sv
tb/sv/tb_top.sv
